/* hdl/olp_pkg.sv */
package olp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } operand_t;

  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  mode;
    logic [2:0]  err_code;
  } result_t;

  // parse phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HASH   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_COMMA  = 3'd3;
  localparam logic [2:0] PH_REG    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // radix codes
  localparam logic [1:0] RDX_DEC = 2'd0;
  localparam logic [1:0] RDX_BIN = 2'd1;
  localparam logic [1:0] RDX_OCT = 2'd2;
  localparam logic [1:0] RDX_HEX = 2'd3;

  // index register select
  localparam logic [1:0] IDX_NONE  = 2'd0;
  localparam logic [1:0] IDX_X     = 2'd1;
  localparam logic [1:0] IDX_Y     = 2'd2;
  localparam logic [1:0] IDX_OTHER = 2'd3;

  // addressing modes
  localparam logic [2:0] MODE_DIRECT   = 3'd0;
  localparam logic [2:0] MODE_EXTENDED = 3'd1;
  localparam logic [2:0] MODE_IMM      = 3'd2;
  localparam logic [2:0] MODE_IDX_X    = 3'd3;
  localparam logic [2:0] MODE_IDX_Y    = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_NUMBER  = 3'd1;
  localparam logic [2:0] ERR_IMM_INDEX  = 3'd2;
  localparam logic [2:0] ERR_NO_REG     = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd4;
  localparam logic [2:0] ERR_BAD_REG    = 3'd5;
  localparam logic [2:0] ERR_TOO_BIG    = 3'd6;
  localparam logic [2:0] ERR_OFFSET_BIG = 3'd7;

  localparam logic [16:0] TOO_BIG   = 17'h10000;
  localparam logic [16:0] MAX_VALUE = 17'h0FFFF;
  localparam logic [16:0] MAX_BYTE  = 17'h000FF;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;

endpackage

/* hdl/operand_literal_parser_unit.sv */
// Operand literal parser: one character item per cycle while not stalled.
// The result is registered when the end item is accepted: into the output
// register if free, else the spare. Throughput: one item per cycle, set by the
// single registered parse step (shift-and-add accumulate); input stalls only
// while a held result and a second finished result in the spare both wait.
// Reset (rst, synchronous): parse state to start of operand, results dropped.
module operand_literal_parser_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_stall,
  input  olp_pkg::operand_t operand,
  output logic              result_valid,
  input  logic              result_stall,
  output olp_pkg::result_t  result
);

  logic [2:0]  phase, phase_next;
  logic [16:0] accum, accum_next;
  logic [1:0]  radix, radix_next;
  logic        imm_flag, imm_flag_next;
  logic [1:0]  index_sel, index_sel_next;
  logic [5:0]  err_flags, err_flags_next;

  logic             accept;
  logic             emit;
  logic             out_free;
  logic             spare_valid;
  olp_pkg::result_t spare;
  olp_pkg::result_t res;

  logic [7:0]  c;
  logic [4:0]  raw_digit;
  logic [4:0]  digit;
  logic [20:0] scaled;
  logic [20:0] sum;
  logic [16:0] acc_add;
  logic [3:0]  add_val;

  assign c             = operand.ch;
  assign operand_stall = spare_valid;
  assign accept        = operand_valid && !operand_stall;
  assign emit          = accept && operand.is_end;
  assign out_free      = !result_valid || !result_stall;

  // digit value in the current radix, 16 if not a digit
  always_comb begin
    raw_digit = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      raw_digit = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      raw_digit = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      raw_digit = 5'(c - 8'h41 + 8'd10);
    end
    digit = 5'd16;
    unique case (radix)
      olp_pkg::RDX_DEC: if (raw_digit < 5'd10) digit = raw_digit;
      olp_pkg::RDX_BIN: if (raw_digit < 5'd2)  digit = raw_digit;
      olp_pkg::RDX_OCT: if (raw_digit < 5'd8)  digit = raw_digit;
      olp_pkg::RDX_HEX: digit = raw_digit;
    endcase
  end

  // accum * base + digit, saturating at TOO_BIG; before a number opens the
  // radix is still decimal, so a leading decimal digit scales a zero accum
  always_comb begin
    add_val = digit[3:0];
    unique case (radix)
      olp_pkg::RDX_DEC: scaled = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0};
      olp_pkg::RDX_BIN: scaled = {3'b000, accum, 1'b0};
      olp_pkg::RDX_OCT: scaled = {1'b0, accum, 3'b000};
      olp_pkg::RDX_HEX: scaled = {accum, 4'b0000};
    endcase
    sum     = scaled + {17'd0, add_val};
    acc_add = (sum > {4'd0, olp_pkg::MAX_VALUE}) ? olp_pkg::TOO_BIG : sum[16:0];
  end

  always_comb begin
    phase_next     = phase;
    accum_next     = accum;
    radix_next     = radix;
    imm_flag_next  = imm_flag;
    index_sel_next = index_sel;
    err_flags_next = err_flags;
    res.value      = 16'd0;
    res.mode       = olp_pkg::MODE_DIRECT;
    res.err_code   = olp_pkg::ERR_NONE;

    if (!operand.is_end) begin
      unique case (phase)
        olp_pkg::PH_START, olp_pkg::PH_HASH: begin
          if (phase == olp_pkg::PH_START && c == olp_pkg::CH_HASH) begin
            imm_flag_next = 1'b1;
            phase_next    = olp_pkg::PH_HASH;
          end else if (c == olp_pkg::CH_PCT) begin
            radix_next = olp_pkg::RDX_BIN;
            phase_next = olp_pkg::PH_DIGITS;
          end else if (c == olp_pkg::CH_AT) begin
            radix_next = olp_pkg::RDX_OCT;
            phase_next = olp_pkg::PH_DIGITS;
          end else if (c == olp_pkg::CH_DOLLAR) begin
            radix_next = olp_pkg::RDX_HEX;
            phase_next = olp_pkg::PH_DIGITS;
          end else if (c >= 8'h30 && c <= 8'h39) begin
            radix_next = olp_pkg::RDX_DEC;
            phase_next = olp_pkg::PH_DIGITS;
            accum_next = acc_add;
          end else begin
            err_flags_next = 6'b000001;
            phase_next     = olp_pkg::PH_DONE;
          end
        end
        olp_pkg::PH_DIGITS: begin
          if (digit != 5'd16) begin
            accum_next = acc_add;
          end else if (c == olp_pkg::CH_COMMA) begin
            if (imm_flag) begin
              err_flags_next = 6'b000010;
              phase_next     = olp_pkg::PH_DONE;
            end else begin
              phase_next = olp_pkg::PH_COMMA;
            end
          end else begin
            err_flags_next = (accum > olp_pkg::MAX_VALUE) ? 6'b100000 : 6'b001000;
            phase_next     = olp_pkg::PH_DONE;
          end
        end
        olp_pkg::PH_COMMA: begin
          index_sel_next = (c == olp_pkg::CH_X) ? olp_pkg::IDX_X :
                           (c == olp_pkg::CH_Y) ? olp_pkg::IDX_Y : olp_pkg::IDX_OTHER;
          phase_next     = olp_pkg::PH_REG;
        end
        olp_pkg::PH_REG: begin
          err_flags_next = 6'b001000;
          phase_next     = olp_pkg::PH_DONE;
        end
        default: ;
      endcase
    end else begin
      unique case (phase)
        olp_pkg::PH_START, olp_pkg::PH_HASH: res.err_code = olp_pkg::ERR_NO_NUMBER;
        olp_pkg::PH_DIGITS: begin
          if (accum > olp_pkg::MAX_VALUE) begin
            res.err_code = olp_pkg::ERR_TOO_BIG;
          end else begin
            res.value = accum[15:0];
            res.mode  = imm_flag ? olp_pkg::MODE_IMM :
                        (accum > olp_pkg::MAX_BYTE) ? olp_pkg::MODE_EXTENDED :
                        olp_pkg::MODE_DIRECT;
          end
        end
        olp_pkg::PH_COMMA: res.err_code = olp_pkg::ERR_NO_REG;
        olp_pkg::PH_REG: begin
          priority if (index_sel == olp_pkg::IDX_OTHER) begin
            res.err_code = olp_pkg::ERR_BAD_REG;
          end else if (accum > olp_pkg::MAX_VALUE) begin
            res.err_code = olp_pkg::ERR_TOO_BIG;
          end else if (accum > olp_pkg::MAX_BYTE) begin
            res.err_code = olp_pkg::ERR_OFFSET_BIG;
          end else begin
            res.value = accum[15:0];
            res.mode  = (index_sel == olp_pkg::IDX_X) ? olp_pkg::MODE_IDX_X :
                        olp_pkg::MODE_IDX_Y;
          end
        end
        default: begin
          priority if (err_flags[0]) res.err_code = olp_pkg::ERR_NO_NUMBER;
          else if (err_flags[1])     res.err_code = olp_pkg::ERR_IMM_INDEX;
          else if (err_flags[3])     res.err_code = olp_pkg::ERR_UNEXPECTED;
          else if (err_flags[5])     res.err_code = olp_pkg::ERR_TOO_BIG;
          else                       res.err_code = olp_pkg::ERR_UNEXPECTED;
        end
      endcase
      // end of operand: back to start
      phase_next     = olp_pkg::PH_START;
      accum_next     = 17'd0;
      radix_next     = olp_pkg::RDX_DEC;
      imm_flag_next  = 1'b0;
      index_sel_next = olp_pkg::IDX_NONE;
      err_flags_next = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= olp_pkg::PH_START;
      accum        <= 17'd0;
      radix        <= olp_pkg::RDX_DEC;
      imm_flag     <= 1'b0;
      index_sel    <= olp_pkg::IDX_NONE;
      err_flags    <= 6'd0;
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        accum     <= accum_next;
        radix     <= radix_next;
        imm_flag  <= imm_flag_next;
        index_sel <= index_sel_next;
        err_flags <= err_flags_next;
      end
      // spare holds a second result while the output register is held
      if (out_free) begin
        result_valid <= spare_valid || emit;
        spare_valid  <= 1'b0;
      end else if (emit) begin
        spare_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (spare_valid || emit)) begin
      result <= spare_valid ? spare : res;
    end
    if (!out_free && emit) begin
      spare <= res;
    end
  end

endmodule
